// File: hdl/ecc_pkg.sv
// Shared types and constants for the elevator car controller.
package ecc_pkg;

  localparam int FLOOR_W = 4;
  localparam int MODE_W  = 3;
  localparam int CMD_W   = 3;
  localparam int DIR_W   = 2;
  localparam int PEND_W  = 5;
  localparam int DWELL_W = 16;
  localparam int CFG_IDX_W = 2;

  // Event codes
  localparam logic [MODE_W-1:0] EV_CABIN       = 3'd0;
  localparam logic [MODE_W-1:0] EV_FLOOR       = 3'd1;
  localparam logic [MODE_W-1:0] EV_HALL        = 3'd2;
  localparam logic [MODE_W-1:0] EV_DOOR_OPENED = 3'd3;
  localparam logic [MODE_W-1:0] EV_DOOR_CLOSED = 3'd4;
  localparam logic [MODE_W-1:0] EV_TICK        = 3'd5;

  // Car commands
  localparam logic [CMD_W-1:0] CMD_NONE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_UP    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DOWN  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_OPEN  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLOSE = 3'd5;

  // Travel direction
  localparam logic [DIR_W-1:0] DIR_NEVER = 2'd0;
  localparam logic [DIR_W-1:0] DIR_UP    = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_DWELL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_DWELL = 2'd1;

  localparam logic [DWELL_W-1:0] STOP_DWELL_RST = 16'd500;
  localparam logic [DWELL_W-1:0] OPEN_DWELL_RST = 16'd3000;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [FLOOR_W-1:0] floor;
    logic               call_up;
  } in_item_t;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [FLOOR_W-1:0] current_floor;
    logic [DIR_W-1:0]   travel_dir;
    logic               door_is_open;
    logic [PEND_W-1:0]  pending_count;
    logic [FLOOR_W-1:0] next_target;
  } out_item_t;

  // Car sequencer states
  typedef enum logic [7:0] {
    SQ_IDLE         = 8'b0000_0001,
    SQ_MOVE_UP      = 8'b0000_0010,
    SQ_MOVE_DOWN    = 8'b0000_0100,
    SQ_OPEN_PENDING = 8'b0000_1000,
    SQ_WAIT_OPENED  = 8'b0001_0000,
    SQ_OPEN_DWELL   = 8'b0010_0000,
    SQ_WAIT_CLOSED  = 8'b0100_0000,
    SQ_STOP_DWELL   = 8'b1000_0000
  } seq_state_e;

  // Transaction phases
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_INS  = 4'b0010,
    PH_SEQ  = 4'b0100,
    PH_OUT  = 4'b1000
  } phase_e;

  typedef struct packed {
    logic             accept;
    logic             ins_step;
    logic             rm_head;
    logic             load_stop;
    logic             load_open;
    logic             dec_dwell;
    logic             door_set;
    logic             door_clr;
    logic             dir_up;
    logic             dir_down;
    logic             cmd_load;
    logic [CMD_W-1:0] code;
    logic             out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              ins_req;
    logic              ins_last;
    logic              pend_nz;
    logic              car_gt_head;
    logic              car_lt_head;
    logic              dwell_le1;
  } dp_sts_t;

endpackage

// File: hdl/ecc_dp.sv
// Datapath: request queue, car registers, dwell counter and result register.
module ecc_dp #(
  parameter int QUEUE_DEPTH = 16,
  parameter int FLOOR_COUNT = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ecc_pkg::in_item_t                   in_i,
  input  logic                                cfg_we_i,
  input  logic [ecc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ecc_pkg::DWELL_W-1:0]         cfg_wdata_i,
  input  ecc_pkg::dp_cmd_t                    cmd_i,
  output ecc_pkg::dp_sts_t                    sts_o,
  output ecc_pkg::out_item_t                  out_o
);

  localparam int IdxW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam int PendW = ecc_pkg::PEND_W;

  logic [ecc_pkg::FLOOR_W-1:0] queue_q [QUEUE_DEPTH];
  logic [CntW-1:0]             pend_q, pend_d;
  logic [IdxW-1:0]             idx_q, idx_d;
  logic [ecc_pkg::FLOOR_W-1:0] carry_q, carry_d;
  logic                        up_q, behind_q;
  ecc_pkg::in_item_t           item_q;
  logic [ecc_pkg::FLOOR_W-1:0] car_q;
  logic [ecc_pkg::DIR_W-1:0]   dir_q;
  logic                        door_q;
  logic [ecc_pkg::DWELL_W-1:0] dwell_q;
  logic [ecc_pkg::DWELL_W-1:0] stop_dwell_q, open_dwell_q;
  logic [ecc_pkg::CMD_W-1:0]   code_q;
  ecc_pkg::out_item_t          out_q;

  logic [ecc_pkg::FLOOR_W-1:0] head, entry;
  logic                        pend_nz, in_ok, item_ok, up_in, behind_in;
  logic                        at_tail, moves, last_idx;
  logic                        q_write;
  logic                        ins_last;

  assign head    = queue_q[0];
  assign entry   = queue_q[idx_q];
  assign pend_nz = (pend_q != '0);
  assign in_ok   = (32'(in_i.floor) < FLOOR_COUNT);
  assign item_ok = (32'(item_q.floor) < FLOOR_COUNT);

  // Ordering and behind-the-car test are taken from the state at accept
  assign up_in = (in_i.mode == ecc_pkg::EV_CABIN) ? (dir_q != ecc_pkg::DIR_DOWN)
                                                  : (in_i.call_up && dir_q == ecc_pkg::DIR_UP);
  assign behind_in = pend_nz && (up_in ? (head > in_i.floor && car_q > in_i.floor)
                                       : (head < in_i.floor && car_q < in_i.floor));

  assign at_tail  = (CntW'(idx_q) >= pend_q);
  assign moves    = up_q ? (entry > carry_q) : (entry < carry_q);
  assign last_idx = (idx_q == IdxW'(QUEUE_DEPTH - 1));

  // One queue entry per insertion step
  always_comb begin
    pend_d   = pend_q;
    idx_d    = idx_q;
    carry_d  = carry_q;
    q_write  = 1'b0;
    ins_last = 1'b0;
    if (cmd_i.accept) begin
      idx_d   = '0;
      carry_d = in_i.floor;
    end else if (cmd_i.ins_step) begin
      if (at_tail) begin
        q_write  = 1'b1;
        pend_d   = CntW'(idx_q) + 1'b1;
        ins_last = 1'b1;
      end else if (!behind_q && moves) begin
        q_write  = 1'b1;
        carry_d  = entry;
        idx_d    = idx_q + 1'b1;
        ins_last = last_idx;
      end else if (entry == carry_q) begin
        ins_last = 1'b1;
      end else begin
        idx_d    = idx_q + 1'b1;
        ins_last = last_idx;
      end
    end else if (cmd_i.rm_head && pend_nz) begin
      pend_d = pend_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_write) begin
      queue_q[idx_q] <= carry_q;
    end else if (cmd_i.rm_head) begin
      for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
        queue_q[k] <= queue_q[k+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q       <= '0;
      idx_q        <= '0;
      car_q        <= '0;
      dir_q        <= ecc_pkg::DIR_NEVER;
      door_q       <= 1'b0;
      dwell_q      <= '0;
      stop_dwell_q <= ecc_pkg::STOP_DWELL_RST;
      open_dwell_q <= ecc_pkg::OPEN_DWELL_RST;
    end else begin
      pend_q <= pend_d;
      idx_q  <= idx_d;
      if (cfg_we_i && cfg_idx_i == ecc_pkg::CFG_STOP_DWELL) begin
        stop_dwell_q <= cfg_wdata_i;
      end
      if (cfg_we_i && cfg_idx_i == ecc_pkg::CFG_OPEN_DWELL) begin
        open_dwell_q <= cfg_wdata_i;
      end
      if (cmd_i.accept && in_i.mode == ecc_pkg::EV_FLOOR && in_ok) begin
        car_q <= in_i.floor;
      end
      if (cmd_i.dir_up) begin
        dir_q <= ecc_pkg::DIR_UP;
      end else if (cmd_i.dir_down) begin
        dir_q <= ecc_pkg::DIR_DOWN;
      end
      if (cmd_i.door_set) begin
        door_q <= 1'b1;
      end else if (cmd_i.door_clr) begin
        door_q <= 1'b0;
      end
      if (cmd_i.load_stop) begin
        dwell_q <= stop_dwell_q;
      end else if (cmd_i.load_open) begin
        dwell_q <= open_dwell_q;
      end else if (cmd_i.dec_dwell) begin
        dwell_q <= dwell_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
    if (cmd_i.accept) begin
      item_q   <= in_i;
      up_q     <= up_in;
      behind_q <= behind_in;
    end
    if (cmd_i.cmd_load) begin
      code_q <= cmd_i.code;
    end
    if (cmd_i.out_load) begin
      out_q.command       <= code_q;
      out_q.current_floor <= car_q;
      out_q.travel_dir    <= dir_q;
      out_q.door_is_open  <= door_q;
      out_q.pending_count <= PendW'(pend_q);
      out_q.next_target   <= pend_nz ? head : '0;
    end
  end

  assign sts_o.mode        = item_q.mode;
  assign sts_o.ins_req     = (item_q.mode == ecc_pkg::EV_CABIN ||
                              item_q.mode == ecc_pkg::EV_HALL) && item_ok;
  assign sts_o.ins_last    = ins_last;
  assign sts_o.pend_nz     = pend_nz;
  assign sts_o.car_gt_head = car_q > head;
  assign sts_o.car_lt_head = car_q < head;
  assign sts_o.dwell_le1   = (dwell_q <= ecc_pkg::DWELL_W'(1));

  assign out_o = out_q;

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= CntW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_idx_in_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ins_step |-> CntW'(idx_q) <= pend_q)
    else $error("insertion index past queue tail");

  a_remove_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rm_head && pend_nz |=> pend_q == $past(pend_q) - 1'b1)
    else $error("head removal did not shrink queue");

endmodule

// File: hdl/ecc_ctrl.sv
// Controller: transaction phases and the door/motion sequencer.
module ecc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  ecc_pkg::dp_sts_t  sts_i,
  output ecc_pkg::dp_cmd_t  cmd_o
);

  ecc_pkg::phase_e     phase_q, phase_d;
  ecc_pkg::seq_state_e seq_q, seq_d;
  logic                out_valid_q, out_valid_d;

  logic                      head_eq_car;
  logic [ecc_pkg::CMD_W-1:0] idle_code;
  ecc_pkg::seq_state_e       idle_next;
  logic                      idle_rm, idle_up, idle_down;

  assign head_eq_car = sts_i.pend_nz && !sts_i.car_gt_head && !sts_i.car_lt_head;

  // Idle evaluation: empty queue, or head below, above or at the car
  always_comb begin
    idle_code = ecc_pkg::CMD_NONE;
    idle_next = ecc_pkg::SQ_IDLE;
    idle_rm   = 1'b0;
    idle_up   = 1'b0;
    idle_down = 1'b0;
    if (sts_i.pend_nz) begin
      if (sts_i.car_gt_head) begin
        idle_code = ecc_pkg::CMD_DOWN;
        idle_next = ecc_pkg::SQ_MOVE_DOWN;
        idle_down = 1'b1;
      end else if (sts_i.car_lt_head) begin
        idle_code = ecc_pkg::CMD_UP;
        idle_next = ecc_pkg::SQ_MOVE_UP;
        idle_up   = 1'b1;
      end else begin
        idle_code = ecc_pkg::CMD_OPEN;
        idle_next = ecc_pkg::SQ_WAIT_OPENED;
        idle_rm   = 1'b1;
      end
    end
  end

  always_comb begin
    cmd_o   = '0;
    phase_d = phase_q;
    seq_d   = seq_q;
    cmd_o.code = ecc_pkg::CMD_NONE;
    case (phase_q)
      ecc_pkg::PH_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          phase_d      = ecc_pkg::PH_INS;
        end
      end
      ecc_pkg::PH_INS: begin
        if (!sts_i.ins_req) begin
          phase_d = ecc_pkg::PH_SEQ;
        end else begin
          cmd_o.ins_step = 1'b1;
          if (sts_i.ins_last) begin
            phase_d = ecc_pkg::PH_SEQ;
          end
        end
      end
      ecc_pkg::PH_SEQ: begin
        cmd_o.cmd_load = 1'b1;
        phase_d        = ecc_pkg::PH_OUT;
        case (seq_q)
          ecc_pkg::SQ_OPEN_PENDING: begin
            cmd_o.code = ecc_pkg::CMD_OPEN;
            seq_d      = ecc_pkg::SQ_WAIT_OPENED;
          end
          ecc_pkg::SQ_WAIT_OPENED: begin
            if (sts_i.mode == ecc_pkg::EV_DOOR_OPENED) begin
              cmd_o.load_open = 1'b1;
              seq_d           = ecc_pkg::SQ_OPEN_DWELL;
            end
          end
          ecc_pkg::SQ_OPEN_DWELL: begin
            if (sts_i.mode == ecc_pkg::EV_TICK) begin
              if (sts_i.dwell_le1) begin
                cmd_o.code     = ecc_pkg::CMD_CLOSE;
                cmd_o.door_set = 1'b1;
                seq_d          = ecc_pkg::SQ_WAIT_CLOSED;
              end else begin
                cmd_o.dec_dwell = 1'b1;
              end
            end
          end
          ecc_pkg::SQ_WAIT_CLOSED: begin
            if (sts_i.mode == ecc_pkg::EV_DOOR_CLOSED) begin
              cmd_o.door_clr = 1'b1;
              cmd_o.code     = idle_code;
              cmd_o.rm_head  = idle_rm;
              cmd_o.dir_up   = idle_up;
              cmd_o.dir_down = idle_down;
              seq_d          = idle_next;
            end
          end
          ecc_pkg::SQ_IDLE: begin
            cmd_o.code     = idle_code;
            cmd_o.rm_head  = idle_rm;
            cmd_o.dir_up   = idle_up;
            cmd_o.dir_down = idle_down;
            seq_d          = idle_next;
          end
          ecc_pkg::SQ_MOVE_UP, ecc_pkg::SQ_MOVE_DOWN: begin
            if (sts_i.mode inside {[ecc_pkg::EV_FLOOR:ecc_pkg::EV_DOOR_CLOSED]} &&
                head_eq_car) begin
              cmd_o.code      = ecc_pkg::CMD_STOP;
              cmd_o.rm_head   = 1'b1;
              cmd_o.load_stop = 1'b1;
              seq_d           = ecc_pkg::SQ_STOP_DWELL;
            end
          end
          ecc_pkg::SQ_STOP_DWELL: begin
            if (sts_i.mode == ecc_pkg::EV_TICK) begin
              if (sts_i.dwell_le1) begin
                cmd_o.code = ecc_pkg::CMD_OPEN;
                seq_d      = ecc_pkg::SQ_WAIT_OPENED;
              end else begin
                cmd_o.dec_dwell = 1'b1;
              end
            end
          end
          default: seq_d = ecc_pkg::SQ_OPEN_PENDING;
        endcase
      end
      ecc_pkg::PH_OUT: begin
        // Load the result register once the previous result has left
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          phase_d        = ecc_pkg::PH_IDLE;
        end
      end
      default: phase_d = ecc_pkg::PH_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ecc_pkg::PH_IDLE;
      seq_q       <= ecc_pkg::SQ_OPEN_PENDING;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      seq_q       <= seq_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (phase_q != ecc_pkg::PH_IDLE);
  assign out_valid_o = out_valid_q;

  a_accept_to_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> phase_q == ecc_pkg::PH_INS)
    else $error("accepted transaction did not enter insertion");

  a_close_from_dwell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.cmd_load && cmd_o.code == ecc_pkg::CMD_CLOSE |->
      seq_q == ecc_pkg::SQ_OPEN_DWELL && sts_i.mode == ecc_pkg::EV_TICK)
    else $error("close issued outside open dwell");

  a_remove_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rm_head |-> sts_i.pend_nz)
    else $error("head removal on empty queue");

endmodule

// File: hdl/elevator_car_controller_core.sv
// Top level of the elevator car controller.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+--------------------------------
//  in      | input     | in_valid_i / in_stall_o   | in_i (mode, floor, call_up)
//  out     | output    | out_valid_o / out_stall_i | out_o (command, floor, dir, ...)
//  cfg     | input     | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// Each transaction passes through the idle (accept), insertion, sequencer and output phases;
// a cabin or hall call to a floor below FLOOR_COUNT visits n (1 to QUEUE_DEPTH) queue
// entries during insertion, one entry per cycle.
// Reset empties the queue and sets the dwells to 500 and 3000 ticks; no clearing pass.
// A waiting result is held under out_stall_i while the next transaction is accepted;
// that transaction finishes once the result register is free.
module elevator_car_controller_core #(
  parameter int QUEUE_DEPTH = 16,
  parameter int FLOOR_COUNT = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ecc_pkg::in_item_t             in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output ecc_pkg::out_item_t            out_o,
  input  logic                          cfg_we_i,
  input  logic [ecc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ecc_pkg::DWELL_W-1:0]   cfg_wdata_i
);

  ecc_pkg::dp_cmd_t dp_cmd;
  ecc_pkg::dp_sts_t dp_sts;

  ecc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  ecc_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .FLOOR_COUNT (FLOOR_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .out_o       (out_o)
  );

endmodule
